[rtl/dlm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared constants and controller/datapath interface types for the
// Damerau-Levenshtein sequence matcher.
// ----------------------------------------------------------------------------
package dlm_pkg;

   localparam int MAX_LEN_DEF  = 64;
   localparam int ALPHABET_DEF = 256;

   localparam int MODE_W  = 2;
   localparam int LABEL_W = 8;
   localparam int THR_W   = 9;
   localparam int DIST_W  = 7;

   localparam logic [THR_W-1:0] THRESH_RESET = 9'd64;

   localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd2;

   // Datapath commands, one step per bit
   typedef struct packed {
      logic append;    // symbol transaction taken
      logic start;     // compare transaction taken
      logic row_init;  // fetch first-sequence symbol, reset column state
      logic rd_b;      // fetch second-sequence symbol
      logic rd_lrs;    // look up last row seen for that symbol
      logic rd_mat;    // read up and transposition cells
      logic calc;      // compute and write one cell
      logic row_end;   // record row in last-row table
      logic ex_rd;     // exact mode: fetch both symbols
      logic ex_cmp;    // exact mode: compare them
      logic finish;    // load result register, clear lengths
   } cmd_type;

   typedef struct packed {
      logic lens_eq;
      logic any_empty;
      logic col_last;
      logic row_last;
      logic ex_last;
      logic sym_eq;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

[rtl/dlm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlm_ctrl
// Sequencer for the matcher: symbol loads, exact scan and the cell loop of
// the distance matrix.
// ----------------------------------------------------------------------------
module dlm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [dlm_pkg::MODE_W-1:0]  req_mode,
   input  wire logic                        req_exact_compare,
   input  wire dlm_pkg::sts_type            sts,
   output dlm_pkg::cmd_type                 cmd,
   output logic                             req_stall
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EX_RD   = 4'd1;
   localparam logic [3:0] S_EX_CMP  = 4'd2;
   localparam logic [3:0] S_ROW     = 4'd3;
   localparam logic [3:0] S_COL     = 4'd4;
   localparam logic [3:0] S_LRS     = 4'd5;
   localparam logic [3:0] S_RD      = 4'd6;
   localparam logic [3:0] S_CALC    = 4'd7;
   localparam logic [3:0] S_ROW_END = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.append   = accept && ((req_mode == dlm_pkg::MODE_FIRST) ||
                                (req_mode == dlm_pkg::MODE_SECOND));
      cmd.start    = accept && (req_mode == dlm_pkg::MODE_COMPARE);
      cmd.row_init = (state_ff == S_ROW);
      cmd.rd_b     = (state_ff == S_COL);
      cmd.rd_lrs   = (state_ff == S_LRS);
      cmd.rd_mat   = (state_ff == S_RD);
      cmd.calc     = (state_ff == S_CALC);
      cmd.row_end  = (state_ff == S_ROW_END);
      cmd.ex_rd    = (state_ff == S_EX_RD);
      cmd.ex_cmp   = (state_ff == S_EX_CMP);
      cmd.finish   = (state_ff == S_DONE) && sts.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               if (req_exact_compare) begin
                  state_in = (sts.lens_eq && !sts.any_empty) ? S_EX_RD : S_DONE;
               end else begin
                  state_in = sts.any_empty ? S_DONE : S_ROW;
               end
            end
         end
         S_EX_RD:   state_in = S_EX_CMP;
         S_EX_CMP:  state_in = (!sts.sym_eq || sts.ex_last) ? S_DONE : S_EX_RD;
         S_ROW:     state_in = S_COL;
         S_COL:     state_in = S_LRS;
         S_LRS:     state_in = S_RD;
         S_RD:      state_in = S_CALC;
         S_CALC:    state_in = sts.col_last ? S_ROW_END : S_COL;
         S_ROW_END: state_in = sts.row_last ? S_DONE : S_ROW;
         S_DONE:    state_in = sts.rsp_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/dlm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlm_datapath
// Sequence stores, last-row table, distance matrix memory, cell arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module dlm_datapath #(
   parameter int MAX_LEN  = dlm_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = dlm_pkg::ALPHABET_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dlm_pkg::cmd_type            cmd,
   output dlm_pkg::sts_type                 sts,
   input  wire logic [dlm_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [dlm_pkg::LABEL_W-1:0] req_label,
   input  wire logic                        req_exact_compare,
   input  wire logic                        csr_write_enable,
   input  wire logic [dlm_pkg::THR_W-1:0]   csr_write_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [dlm_pkg::DIST_W-1:0]       rsp_distance,
   output logic                             rsp_is_match,
   output logic                             rsp_overflow
);

   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DW   = $clog2(2 * MAX_LEN + 1);
   localparam int CW   = $clog2(MAX_LEN + 2);
   localparam int DIM  = MAX_LEN + 2;
   localparam int AW   = $clog2(DIM * DIM);
   localparam int LD   = (ALPHABET < 256) ? ALPHABET : 256;
   localparam int SW   = $clog2(LD);
   localparam int XW   = (DW > dlm_pkg::DIST_W) ? DW : dlm_pkg::DIST_W;
   localparam int SUMW = DW + 2;
   localparam int PW   = DW + 8 + dlm_pkg::THR_W + LW;

   // Storage
   logic [SW-1:0] first_mem [MAX_LEN];
   logic [SW-1:0] second_mem [MAX_LEN];
   logic [LW-1:0] lrs_mem [LD];
   logic [DW-1:0] mat_mem [DIM*DIM];

   logic [LW-1:0]  len1_ff, len2_ff;
   logic           drop_ff;
   logic [dlm_pkg::THR_W-1:0] thr_ff;
   logic [LW-1:0]  ri_ff, cj_ff, cm_ff, pi_ff;
   logic           exact_ff, eq_ff;
   logic [SW-1:0]  a_q_ff, b_q_ff;
   logic [LW-1:0]  lrs_q_ff;
   logic           lrs_vq_ff;
   logic [LD-1:0]  lrs_val_ff;
   logic           up_bor_ff, tr_bor_ff;
   logic [DW-1:0]  up_bv_ff, tr_bv_ff, up_q_ff, tr_q_ff;
   logic [DW-1:0]  diag_ff, left_ff;
   logic           rsp_valid_ff;
   logic [dlm_pkg::DIST_W-1:0] rsp_dist_ff;
   logic           rsp_match_ff, rsp_ovf_ff;

   logic [SW-1:0]  sym_in;
   logic           wr_first, wr_second;
   logic           first_re, second_re;
   logic [IW-1:0]  first_ra;
   logic [LW-1:0]  pi_val;
   logic [DW-1:0]  big;
   logic [AW-1:0]  up_addr, tr_addr, wr_addr;
   logic [DW-1:0]  up_v, tr_m, cell_val;
   logic [SUMW-1:0] sub_s, ins_s, del_s, trn_s, min_s;
   logic [DW-1:0]  dist_val;
   logic [LW-1:0]  longer;
   logic           fz_match;
   logic [XW-1:0]  dist_x;

   function automatic logic [AW-1:0] mat_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
      mat_addr = AW'(r) * AW'(DIM) + AW'(c);
   endfunction

   // Row/column zero hold the guard value; row/column one hold 0..len.
   function automatic logic [DW-1:0] border_val(input logic [LW-1:0] r,
                                                input logic [LW-1:0] c,
                                                input logic [DW-1:0] g);
      if (r == '0 || c == '0) begin
         border_val = g;
      end else if (r == LW'(1)) begin
         border_val = DW'(c) - DW'(1);
      end else begin
         border_val = DW'(r) - DW'(1);
      end
   endfunction

   assign sym_in = (int'(req_label) >= ALPHABET) ? SW'(ALPHABET - 1) : SW'(req_label);
   assign wr_first  = cmd.append && (req_mode == dlm_pkg::MODE_FIRST)
                      && (len1_ff != LW'(MAX_LEN));
   assign wr_second = cmd.append && (req_mode == dlm_pkg::MODE_SECOND)
                      && (len2_ff != LW'(MAX_LEN));
   assign first_re  = cmd.row_init || cmd.ex_rd;
   assign second_re = cmd.rd_b || cmd.ex_rd;
   assign first_ra  = cmd.ex_rd ? cj_ff[IW-1:0] : ri_ff[IW-1:0];

   assign big    = DW'(len1_ff) + DW'(len2_ff);
   assign pi_val = lrs_vq_ff ? lrs_q_ff : '0;

   // Matrix coordinates: row i = ri+1, col j = cj+1; up is (i, j+1)
   assign up_addr = mat_addr(CW'(ri_ff) + CW'(1), CW'(cj_ff) + CW'(2));
   assign tr_addr = mat_addr(CW'(pi_val), CW'(cm_ff));
   assign wr_addr = mat_addr(CW'(ri_ff) + CW'(2), CW'(cj_ff) + CW'(2));

   always_comb begin
      up_v  = up_bor_ff ? up_bv_ff : up_q_ff;
      tr_m  = tr_bor_ff ? tr_bv_ff : tr_q_ff;
      sub_s = SUMW'(diag_ff) + SUMW'(a_q_ff != b_q_ff);
      ins_s = SUMW'(left_ff) + SUMW'(1);
      del_s = SUMW'(up_v) + SUMW'(1);
      trn_s = SUMW'(tr_m) + SUMW'(ri_ff) + SUMW'(cj_ff) + SUMW'(1)
              - SUMW'(pi_ff) - SUMW'(cm_ff);
      min_s = sub_s;
      if (ins_s < min_s) min_s = ins_s;
      if (del_s < min_s) min_s = del_s;
      if (trn_s < min_s) min_s = trn_s;
      cell_val = min_s[DW-1:0];
   end

   // Result
   always_comb begin
      if (len1_ff == '0) begin
         dist_val = DW'(len2_ff);
      end else if (len2_ff == '0) begin
         dist_val = DW'(len1_ff);
      end else begin
         dist_val = left_ff;
      end
      longer   = (len1_ff > len2_ff) ? len1_ff : len2_ff;
      // distance*256 < threshold*longer
      fz_match = PW'({dist_val, 8'd0}) < (PW'(thr_ff) * PW'(longer));
      dist_x   = exact_ff ? '0 : XW'(dist_val);
   end

   assign sts.lens_eq   = (len1_ff == len2_ff);
   assign sts.any_empty = (len1_ff == '0) || (len2_ff == '0);
   assign sts.col_last  = (LW'(cj_ff + LW'(1)) == len2_ff);
   assign sts.row_last  = (LW'(ri_ff + LW'(1)) == len1_ff);
   assign sts.ex_last   = (LW'(cj_ff + LW'(1)) == len1_ff);
   assign sts.sym_eq    = (a_q_ff == b_q_ff);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (wr_first) first_mem[len1_ff[IW-1:0]] <= sym_in;
      if (first_re) a_q_ff <= first_mem[first_ra];
   end

   always_ff @(posedge clock) begin
      if (wr_second) second_mem[len2_ff[IW-1:0]] <= sym_in;
      if (second_re) b_q_ff <= second_mem[cj_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.row_end) lrs_mem[a_q_ff] <= LW'(ri_ff + LW'(1));
      if (cmd.rd_lrs) lrs_q_ff <= lrs_mem[b_q_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) mat_mem[wr_addr] <= cell_val;
      if (cmd.rd_mat) begin
         up_q_ff <= mat_mem[up_addr];
         tr_q_ff <= mat_mem[tr_addr];
      end
   end

   // Cell datapath and result registers
   always_ff @(posedge clock) begin
      if (cmd.rd_lrs) lrs_vq_ff <= lrs_val_ff[b_q_ff];
      if (cmd.start) begin
         exact_ff <= req_exact_compare;
         eq_ff    <= (len1_ff == len2_ff);
      end
      if (cmd.ex_cmp && (a_q_ff != b_q_ff)) eq_ff <= 1'b0;
      if (cmd.row_init) begin
         cm_ff   <= '0;
         diag_ff <= DW'(ri_ff);
         left_ff <= DW'(ri_ff) + DW'(1);
      end
      if (cmd.rd_mat) begin
         pi_ff     <= pi_val;
         up_bor_ff <= (ri_ff == '0);
         up_bv_ff  <= DW'(cj_ff) + DW'(1);
         tr_bor_ff <= (pi_val <= LW'(1)) || (cm_ff <= LW'(1));
         tr_bv_ff  <= border_val(pi_val, cm_ff, big);
      end
      if (cmd.calc) begin
         diag_ff <= up_v;
         left_ff <= cell_val;
         if (a_q_ff == b_q_ff) cm_ff <= LW'(cj_ff + LW'(1));
      end
      if (cmd.finish) begin
         rsp_dist_ff  <= (dist_x > XW'(127)) ? 7'd127 : dist_x[dlm_pkg::DIST_W-1:0];
         rsp_match_ff <= exact_ff ? eq_ff : fz_match;
         rsp_ovf_ff   <= drop_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff      <= '0;
         len2_ff      <= '0;
         drop_ff      <= 1'b0;
         thr_ff       <= dlm_pkg::THRESH_RESET;
         ri_ff        <= '0;
         cj_ff        <= '0;
         lrs_val_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) thr_ff <= csr_write_data;
         if (wr_first) len1_ff <= LW'(len1_ff + LW'(1));
         if (wr_second) len2_ff <= LW'(len2_ff + LW'(1));
         if (cmd.append && !wr_first && !wr_second &&
             ((req_mode == dlm_pkg::MODE_FIRST) || (req_mode == dlm_pkg::MODE_SECOND))) begin
            drop_ff <= 1'b1;
         end
         if (cmd.start) begin
            ri_ff      <= '0;
            cj_ff      <= '0;
            lrs_val_ff <= '0;
         end
         if (cmd.row_init) cj_ff <= '0;
         if ((cmd.calc && !sts.col_last) || cmd.ex_cmp) cj_ff <= LW'(cj_ff + LW'(1));
         if (cmd.row_end) begin
            lrs_val_ff[a_q_ff] <= 1'b1;
            ri_ff              <= LW'(ri_ff + LW'(1));
         end
         if (cmd.finish) begin
            len1_ff      <= '0;
            len2_ff      <= '0;
            drop_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_is_match = rsp_match_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

[rtl/damerau_levenshtein_match.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// damerau_levenshtein_match
// Loads two label sequences and compares them exactly or by
// Damerau-Levenshtein distance against a Q1.8 ratio threshold.
// ----------------------------------------------------------------------------
// Symbol transactions (mode 0/1) cause no stall of the request side. A
// compare holds it stalled while it runs: an exact compare alternates symbol
// fetch and compare steps per symbol pair; a fuzzy compare steps through
// column fetch, last-row lookup and matrix read, then computes each cell,
// with row setup and row end per row; a final step loads the result register.
// Symbols past MAX_LEN are dropped and reported through rsp_overflow; both
// lengths clear after every compare. No clearing pass follows reset.
module damerau_levenshtein_match #(
   parameter int MAX_LEN  = dlm_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = dlm_pkg::ALPHABET_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [dlm_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [dlm_pkg::LABEL_W-1:0] req_label,
   input  wire logic                        req_exact_compare,
   input  wire logic                        csr_write_enable,
   input  wire logic [dlm_pkg::THR_W-1:0]   csr_write_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [dlm_pkg::DIST_W-1:0]       rsp_distance,
   output logic                             rsp_is_match,
   output logic                             rsp_overflow
);

   dlm_pkg::cmd_type cmd;
   dlm_pkg::sts_type sts;

   dlm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_mode          (req_mode),
      .req_exact_compare (req_exact_compare),
      .sts               (sts),
      .cmd               (cmd),
      .req_stall         (req_stall)
   );

   dlm_datapath #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_label         (req_label),
      .req_exact_compare (req_exact_compare),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .rsp_is_match      (rsp_is_match),
      .rsp_overflow      (rsp_overflow)
   );

`ifndef SYNTHESIS
   // A compare transaction always stalls the request side in the cycle after it is taken
   a_cmp_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_mode == dlm_pkg::MODE_COMPARE)) |=> req_stall)
      else $error("compare transaction did not stall the request side");

   // A new result only appears at the end of a compare
   a_rsp_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result produced outside a compare");

   // Symbol transactions never produce a result
   a_no_rsp_on_load: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid && !req_stall &&
       (req_mode != dlm_pkg::MODE_COMPARE)) |=> !rsp_valid)
      else $error("result produced by a symbol transaction");
`endif

endmodule
`default_nettype wire

[verif/damerau_levenshtein_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damerau_levenshtein_match_test
// Loads random and directed label sequences, runs exact and fuzzy compares
// under several thresholds with random idle and stall, and checks every
// result against an in-bench distance predictor.
// ----------------------------------------------------------------------------

class dlm_scoreboard;
   typedef struct packed {
      logic [6:0] distance;
      logic       is_match;
      logic       overflow;
   } match_result_type;

   logic [8:0]  threshold;
   logic [7:0]  seq_a[64];
   logic [7:0]  seq_b[64];
   int          len_a;
   int          len_b;
   bit          dropped;
   match_result_type pending[$];
   int          errors;
   int          compares;

   function new();
      threshold = dlm_pkg::THRESH_RESET;
      len_a = 0;
      len_b = 0;
      dropped = 0;
      errors = 0;
      compares = 0;
   endfunction

   function int edit_distance();
      int m[66][66];
      int last_row[256];
      int big, i, j, col_hit, pi, pj, c, v;
      big = len_a + len_b;
      foreach (last_row[k]) last_row[k] = 0;
      m[0][0] = big;
      for (i = 0; i <= len_a; i++) begin
         m[i+1][0] = big;
         m[i+1][1] = i;
      end
      for (j = 0; j <= len_b; j++) begin
         m[0][j+1] = big;
         m[1][j+1] = j;
      end
      for (i = 1; i <= len_a; i++) begin
         col_hit = 0;
         for (j = 1; j <= len_b; j++) begin
            pi = last_row[seq_b[j-1]];
            pj = col_hit;
            c = (seq_a[i-1] == seq_b[j-1]) ? 0 : 1;
            if (c == 0) col_hit = j;
            v = m[i][j] + c;
            if (m[i+1][j] + 1 < v) v = m[i+1][j] + 1;
            if (m[i][j+1] + 1 < v) v = m[i][j+1] + 1;
            if (m[pi][pj] + (i - pi - 1) + 1 + (j - pj - 1) < v)
               v = m[pi][pj] + (i - pi - 1) + 1 + (j - pj - 1);
            m[i+1][j+1] = v;
         end
         last_row[seq_a[i-1]] = i;
      end
      return m[len_a+1][len_b+1];
   endfunction

   function void note_request(logic [1:0] mode, logic [7:0] label, logic exact);
      match_result_type r;
      int d, longer;
      bit eq;
      if (mode == dlm_pkg::MODE_FIRST) begin
         if (len_a >= 64) dropped = 1;
         else begin
            seq_a[len_a] = label;
            len_a++;
         end
      end else if (mode == dlm_pkg::MODE_SECOND) begin
         if (len_b >= 64) dropped = 1;
         else begin
            seq_b[len_b] = label;
            len_b++;
         end
      end else if (mode == dlm_pkg::MODE_COMPARE) begin
         d = 0;
         if (exact) begin
            eq = (len_a == len_b);
            for (int k = 0; k < len_a && eq; k++)
               if (seq_a[k] != seq_b[k]) eq = 0;
         end else begin
            longer = (len_a > len_b) ? len_a : len_b;
            d = edit_distance();
            eq = (d * 256) < (int'(threshold) * longer);
         end
         r.distance = (d > 127) ? 7'd127 : d[6:0];
         r.is_match = eq;
         r.overflow = dropped;
         pending.push_back(r);
         len_a = 0;
         len_b = 0;
         dropped = 0;
      end
   endfunction

   function void check_result(logic [6:0] distance, logic is_match, logic overflow);
      match_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result dist=%0d match=%0b ovf=%0b",
                  $time, distance, is_match, overflow);
         errors++;
         return;
      end
      e = pending.pop_front();
      compares++;
      if (distance !== e.distance) begin
         $display("%0t: distance expected %0d actual %0d", $time, e.distance, distance);
         errors++;
      end
      if (is_match !== e.is_match) begin
         $display("%0t: is_match expected %0b actual %0b", $time, e.is_match, is_match);
         errors++;
      end
      if (overflow !== e.overflow) begin
         $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, overflow);
         errors++;
      end
   endfunction
endclass

module damerau_levenshtein_match_test;

   localparam int CYCLE_LIMIT = 3000000;
   // mode code the block ignores
   localparam logic [dlm_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [dlm_pkg::MODE_W-1:0]    req_mode;
   logic [dlm_pkg::LABEL_W-1:0]   req_label;
   logic                          req_exact_compare;
   logic                          csr_write_enable;
   logic [dlm_pkg::THR_W-1:0]     csr_write_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [dlm_pkg::DIST_W-1:0]    rsp_distance;
   logic                          rsp_is_match;
   logic                          rsp_overflow;

   dlm_scoreboard sb;
   int cycles;
   int sent;
   bit no_idle;
   int rsp_wait;
   int rsp_draw;

   damerau_levenshtein_match u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_label(req_label), .req_exact_compare(req_exact_compare),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .rsp_is_match(rsp_is_match), .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_mode = dlm_pkg::MODE_FIRST;
      req_label = 0;
      req_exact_compare = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      rsp_stall = 0;
      rsp_wait = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("damerau_levenshtein_match_test: errors");
         $finish;
      end
   end
   initial cycles = 0;

   // result side: after each accepted result, stall for a randomly drawn wait, none when no_idle is set
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_distance, rsp_is_match, rsp_overflow);
            rsp_draw = no_idle ? 0 : $urandom_range(0, 6);
            rsp_wait <= rsp_draw;
            rsp_stall <= (rsp_draw != 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_stall <= (rsp_wait > 1);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(input logic [1:0] mode, input logic [7:0] label, input logic exact);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_label <= label;
      req_exact_compare <= exact;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, label, exact);
      sent++;
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [8:0] value);
      go_idle();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.threshold = value;
   endtask

   // random pair of sequences and one compare
   task automatic random_pair(input int max_len);
      int la, lb, alpha;
      logic [7:0] base[64];
      la = $urandom_range(0, max_len);
      lb = $urandom_range(0, max_len);
      alpha = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 4);
      for (int k = 0; k < 64; k++) base[k] = 8'($urandom_range(0, alpha));
      for (int k = 0; k < la; k++)
         send(dlm_pkg::MODE_FIRST, base[k], 1'($urandom_range(0, 1)));
      for (int k = 0; k < lb; k++) begin
         // mostly a lightly edited copy of the first sequence
         if ($urandom_range(0, 3) == 0)
            send(dlm_pkg::MODE_SECOND, 8'($urandom_range(0, alpha)), 1'b0);
         else send(dlm_pkg::MODE_SECOND, base[k], 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) send(MODE_NONE, 8'($urandom), 1'($urandom));
      send(dlm_pkg::MODE_COMPARE, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      logic [8:0] thr_list[5];
      thr_list = '{9'd0, 9'd256, 9'd128, 9'd1, 9'd511};
      sent = 0;
      no_idle = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty compares, extreme labels, transposition, unused mode
      send(dlm_pkg::MODE_COMPARE, 8'h00, 1'b0);
      send(dlm_pkg::MODE_COMPARE, 8'hFF, 1'b1);
      send(dlm_pkg::MODE_FIRST, 8'h00, 1'b0);
      send(dlm_pkg::MODE_FIRST, 8'hFF, 1'b1);
      send(dlm_pkg::MODE_SECOND, 8'hFF, 1'b0);
      send(dlm_pkg::MODE_SECOND, 8'h00, 1'b1);
      send(MODE_NONE, 8'hAA, 1'b1);
      send(dlm_pkg::MODE_COMPARE, 8'h55, 1'b0);
      send(dlm_pkg::MODE_FIRST, 8'hA5, 1'b0);
      send(dlm_pkg::MODE_SECOND, 8'hA5, 1'b0);
      send(dlm_pkg::MODE_COMPARE, 8'h00, 1'b1);
      send(dlm_pkg::MODE_FIRST, 8'h12, 1'b0);
      send(dlm_pkg::MODE_COMPARE, 8'h00, 1'b0);
      // full sequences and dropped symbols
      go_idle();
      for (int k = 0; k < 65; k++) send(dlm_pkg::MODE_FIRST, 8'($urandom), 1'b0);
      for (int k = 0; k < 66; k++) send(dlm_pkg::MODE_SECOND, 8'($urandom), 1'b0);
      send(dlm_pkg::MODE_COMPARE, 8'h00, 1'b0);
      for (int k = 0; k < 65; k++) send(dlm_pkg::MODE_SECOND, 8'(k), 1'b0);
      send(dlm_pkg::MODE_COMPARE, 8'h00, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 5) set_threshold(thr_list[ph]);
         else set_threshold(dlm_pkg::THRESH_RESET);
         no_idle = (ph == 2);
         while (sent < 180 + ph * 240) random_pair($urandom_range(0, 7) == 0 ? 64 : 10);
      end

      go_idle();
      $display("covered %0d request transactions and %0d compare results", sent, sb.compares);
      $display("thresholds 0, 1, 64, 128, 256, 511; exact and fuzzy; overflow and empty sets");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("damerau_levenshtein_match_test: clean");
      else
         $display("damerau_levenshtein_match_test: errors");
      $finish;
   end
endmodule

[filelist.f]
rtl/dlm_pkg.sv
rtl/dlm_ctrl.sv
rtl/dlm_datapath.sv
rtl/damerau_levenshtein_match.sv
verif/damerau_levenshtein_match_test.sv
